>>> hdl/tlt_pkg.sv
// Shared types, token and mode codes, and character constants of the tokenizer.
package tlt_pkg;

  // Field widths of the channel words.
  localparam int KIND_W  = 5;
  localparam int LEN_W   = 16;
  localparam int VALUE_W = 31;

  // Default width of the token length counter.
  localparam int LEN_BITS_DEF = 16;

  // Depth of the result queue; ready needs room for two words.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Largest number value.
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // Token kinds.
  localparam logic [KIND_W-1:0] K_NAME    = 5'd0;
  localparam logic [KIND_W-1:0] K_INT     = 5'd1;
  localparam logic [KIND_W-1:0] K_STR     = 5'd2;
  localparam logic [KIND_W-1:0] K_REAL    = 5'd3;
  localparam logic [KIND_W-1:0] K_LARROW  = 5'd4;
  localparam logic [KIND_W-1:0] K_RARROW  = 5'd5;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd6;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd7;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd8;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd9;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd10;
  localparam logic [KIND_W-1:0] K_FN      = 5'd11;
  localparam logic [KIND_W-1:0] K_EQUALS  = 5'd12;
  localparam logic [KIND_W-1:0] K_SPACE   = 5'd13;
  localparam logic [KIND_W-1:0] K_COMMENT = 5'd14;
  localparam logic [KIND_W-1:0] K_EOF     = 5'd15;
  localparam logic [KIND_W-1:0] K_ERROR   = 5'd16;

  // Scanner modes.
  localparam int MODE_W = 4;
  localparam logic [MODE_W-1:0] M_IDLE     = 4'd0;
  localparam logic [MODE_W-1:0] M_WS       = 4'd1;
  localparam logic [MODE_W-1:0] M_COMMENT  = 4'd2;
  localparam logic [MODE_W-1:0] M_AFTER_F  = 4'd3;
  localparam logic [MODE_W-1:0] M_AFTER_EQ = 4'd4;
  localparam logic [MODE_W-1:0] M_AFTER_LT = 4'd5;
  localparam logic [MODE_W-1:0] M_STRING   = 4'd6;
  localparam logic [MODE_W-1:0] M_INT      = 4'd7;
  localparam logic [MODE_W-1:0] M_REAL     = 4'd8;
  localparam logic [MODE_W-1:0] M_NAME     = 4'd9;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_DIG0   = 8'd48;
  localparam logic [7:0] CH_DIG9   = 8'd57;
  localparam logic [7:0] CH_SEMI   = 8'd59;
  localparam logic [7:0] CH_LT     = 8'd60;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_F      = 8'd102;
  localparam logic [7:0] CH_N      = 8'd110;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_RBRACE = 8'd125;
  localparam logic [7:0] NAME_LO   = 8'd35;
  localparam logic [7:0] NAME_HI   = 8'd136;

  // One result word.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   length;
    logic [VALUE_W-1:0] value;
    logic               last;
  } res_t;

  // Words produced by one accepted byte, oldest in res0.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  // Bytes that end a name.
  function automatic logic is_delim(input logic [7:0] c);
    return is_space(c) || (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

endpackage

>>> hdl/tlt_in_if.sv
// Source byte channel of the tokenizer.
interface tlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

>>> hdl/tlt_out_if.sv
// Token result channel of the tokenizer.
interface tlt_out_if import tlt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [LEN_W-1:0]   token_length;
  logic [VALUE_W-1:0] number_value;
  logic               last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output number_value, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_length,
                  input number_value, input last_of_run, output ready);
endinterface

>>> hdl/toy_language_tokenizer.sv
// Top level of the streaming tokenizer: scanner and result queue.
// A token closed by a byte accepted at one edge is on out_ch from the next cycle
// when no earlier word waits in the queue.
// Throughput: one source byte per cycle; a byte that yields two tokens adds two words
// to the four-entry result queue, and in_ch.ready drops while more than two words wait.
// Reset (rst_n low, synchronous): scanner idle with no token pending, queue empty,
// whitespace drop set to 1.
module toy_language_tokenizer import tlt_pkg::*; #(
  parameter int LENGTH_BITS = LEN_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tlt_in_if.sink    in_ch,
  tlt_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic  space_ok;
  logic  in_fire;
  push_t push;

  // A source word is taken whenever the queue has room for two results.
  assign in_ch.ready = space_ok;
  assign in_fire     = in_ch.valid && space_ok;

  tlt_scan #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .char_code    (in_ch.char_code),
    .end_of_input (in_ch.end_of_input),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .push         (push)
  );

  tlt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (in_fire),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule

>>> hdl/tlt_scan.sv
// Scanner state and the per-byte step logic that forms up to two tokens.
module tlt_scan import tlt_pkg::*; #(
  parameter int LENGTH_BITS = LEN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output push_t      push
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] run_r, run_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;
  logic                   drop_ws_r;

  logic                   stop;
  logic [LENGTH_BITS-1:0] grown;
  logic [35:0]            acc_times;
  logic [VALUE_W-1:0]     acc_step;
  logic                   restart;

  // Token closed by the pending mode.
  logic                   f_v;
  logic [KIND_W-1:0]      f_kind;
  logic [LENGTH_BITS-1:0] f_len;
  logic [VALUE_W-1:0]     f_val;

  // Token or mode opened by the byte.
  logic [MODE_W-1:0]      s_mode;
  logic                   s_v;
  logic [KIND_W-1:0]      s_kind;

  // Raw result slots before whitespace dropping.
  logic                   r0_v, r1_v, k0_v, k1_v;
  logic [KIND_W-1:0]      r0_kind, r1_kind;
  logic [LENGTH_BITS-1:0] r0_len, r1_len;
  logic [VALUE_W-1:0]     r0_val, r1_val;
  res_t                   w0, w1;

  // Token length on the 16-bit field: low bits of the counter.
  function automatic logic [LEN_W-1:0] to_len(input logic [LENGTH_BITS-1:0] x);
    logic [31:0] t;
    t = 32'(x);
    return t[LEN_W-1:0];
  endfunction

  assign stop  = end_of_input || (char_code == CH_NUL);
  assign grown = (run_r == LEN_MAX) ? run_r : run_r + LEN_ONE;

  // Decimal accumulate, acc*10 + digit, saturating.
  assign acc_times = (36'(acc_r) << 3) + (36'(acc_r) << 1) + 36'(char_code[3:0]);
  assign acc_step  = (acc_times > 36'(VALUE_MAX)) ? VALUE_MAX : acc_times[VALUE_W-1:0];

  // Flush of the pending token.
  always_comb begin
    f_v    = 1'b1;
    f_kind = K_NAME;
    f_len  = run_r;
    f_val  = '0;
    unique case (mode_r)
      M_WS:       f_kind = K_SPACE;
      M_COMMENT:  f_kind = K_COMMENT;
      M_AFTER_F,
      M_AFTER_LT,
      M_NAME:     f_kind = K_NAME;
      M_AFTER_EQ: begin
        f_kind = K_EQUALS;
        f_len  = LEN_ONE;
      end
      M_STRING:   f_kind = K_ERROR;
      M_INT: begin
        f_kind = K_INT;
        f_val  = acc_r;
      end
      M_REAL: begin
        f_kind = K_REAL;
        f_val  = acc_r;
      end
      default:    f_v = 1'b0;
    endcase
  end

  // Start of a new token at this byte.
  always_comb begin
    s_mode = M_IDLE;
    s_v    = 1'b0;
    s_kind = K_ERROR;
    if (is_space(char_code)) begin
      s_mode = M_WS;
    end else if (char_code == CH_LPAREN) begin
      s_v = 1'b1; s_kind = K_LPAREN;
    end else if (char_code == CH_RPAREN) begin
      s_v = 1'b1; s_kind = K_RPAREN;
    end else if (char_code == CH_LBRACE) begin
      s_v = 1'b1; s_kind = K_LBRACE;
    end else if (char_code == CH_RBRACE) begin
      s_v = 1'b1; s_kind = K_RBRACE;
    end else if (char_code == CH_SEMI) begin
      s_v = 1'b1; s_kind = K_SEMI;
    end else if (char_code == CH_HASH) begin
      s_mode = M_COMMENT;
    end else if (char_code == CH_F) begin
      s_mode = M_AFTER_F;
    end else if (char_code == CH_EQ) begin
      s_mode = M_AFTER_EQ;
    end else if (char_code == CH_LT) begin
      s_mode = M_AFTER_LT;
    end else if (char_code == CH_QUOTE) begin
      s_mode = M_STRING;
    end else if (is_digit(char_code)) begin
      s_mode = M_INT;
    end else if (char_code >= NAME_LO && char_code <= NAME_HI) begin
      s_mode = M_NAME;
    end else begin
      s_v = 1'b1; s_kind = K_ERROR;
    end
  end

  // Step of the scanner for one accepted word.
  always_comb begin
    mode_nxt = mode_r;
    run_nxt  = run_r;
    acc_nxt  = acc_r;
    restart  = 1'b0;
    r0_v     = 1'b0;
    r0_kind  = K_NAME;
    r0_len   = '0;
    r0_val   = '0;
    r1_v     = 1'b0;
    r1_kind  = K_NAME;
    r1_len   = '0;
    r1_val   = '0;
    if (stop) begin
      r0_v     = f_v;
      r0_kind  = f_kind;
      r0_len   = f_len;
      r0_val   = f_val;
      r1_v     = 1'b1;
      r1_kind  = K_EOF;
      mode_nxt = M_IDLE;
      run_nxt  = '0;
      acc_nxt  = '0;
    end else begin
      unique case (mode_r)
        M_WS: begin
          if (is_space(char_code)) run_nxt = grown;
          else restart = 1'b1;
        end
        M_COMMENT: begin
          if (char_code != CH_NL) run_nxt = grown;
          else restart = 1'b1;
        end
        M_AFTER_F,
        M_AFTER_LT: begin
          if ((mode_r == M_AFTER_F && char_code == CH_N) ||
              (mode_r == M_AFTER_LT && char_code == CH_DASH)) begin
            r0_v     = 1'b1;
            r0_kind  = (mode_r == M_AFTER_F) ? K_FN : K_LARROW;
            r0_len   = LEN_TWO;
            mode_nxt = M_IDLE;
            run_nxt  = '0;
          end else if (!is_delim(char_code)) begin
            mode_nxt = M_NAME;
            run_nxt  = grown;
          end else begin
            restart = 1'b1;
          end
        end
        M_AFTER_EQ: begin
          if (char_code == CH_GT) begin
            r0_v     = 1'b1;
            r0_kind  = K_RARROW;
            r0_len   = LEN_TWO;
            mode_nxt = M_IDLE;
            run_nxt  = '0;
          end else begin
            restart = 1'b1;
          end
        end
        M_STRING: begin
          if (char_code == CH_QUOTE) begin
            r0_v     = 1'b1;
            r0_kind  = K_STR;
            r0_len   = grown;
            mode_nxt = M_IDLE;
            run_nxt  = '0;
          end else begin
            run_nxt = grown;
          end
        end
        M_INT: begin
          if (is_digit(char_code)) begin
            acc_nxt = acc_step;
            run_nxt = grown;
          end else if (char_code == CH_DOT) begin
            mode_nxt = M_REAL;
            run_nxt  = grown;
          end else begin
            restart = 1'b1;
          end
        end
        M_REAL: begin
          if (is_digit(char_code)) run_nxt = grown;
          else restart = 1'b1;
        end
        M_NAME: begin
          if (!is_delim(char_code)) run_nxt = grown;
          else restart = 1'b1;
        end
        default: restart = 1'b1;
      endcase

      // Close the pending token and open one at this byte.
      if (restart) begin
        r0_v     = f_v;
        r0_kind  = f_kind;
        r0_len   = f_len;
        r0_val   = f_val;
        r1_v     = s_v;
        r1_kind  = s_kind;
        r1_len   = LEN_ONE;
        mode_nxt = s_mode;
        run_nxt  = (s_mode != M_IDLE) ? LEN_ONE : '0;
        acc_nxt  = (s_mode == M_INT) ? VALUE_W'(char_code[3:0]) : '0;
      end
    end
  end

  // Drop whitespace tokens when dropping is set, pack the kept words and mark the last one.
  always_comb begin
    k0_v = r0_v && !(drop_ws_r && r0_kind == K_SPACE);
    k1_v = r1_v && !(drop_ws_r && r1_kind == K_SPACE);
    w0   = '{kind: r0_kind, length: to_len(r0_len), value: r0_val, last: !k1_v};
    w1   = '{kind: r1_kind, length: to_len(r1_len), value: r1_val, last: 1'b1};
    push.count = {1'b0, k0_v} + {1'b0, k1_v};
    if (k0_v) begin
      push.res0 = w0;
      push.res1 = w1;
    end else begin
      push.res0 = w1;
      push.res1 = w1;
    end
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      run_r  <= '0;
      acc_r  <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Whitespace drop register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_ws_r <= 1'b1;
    end else if (cfg_wr_en) begin
      drop_ws_r <= cfg_wr_data;
    end
  end

  // A pending token always has a nonzero length.
  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != M_IDLE) |-> (run_r != '0))
    else $error("pending token with zero length");

  // An end marker leaves the scanner idle and cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && stop) |=> (mode_r == M_IDLE && run_r == '0 && acc_r == '0))
    else $error("scanner not cleared after end of input");

  // Of two words from one byte, only the second is marked last.
  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count == 2'd2) |-> (push.res1.last && !push.res0.last))
    else $error("bad last marking on a pair of words");

  // Number values appear only on number tokens.
  a_value_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0 && push.res0.value != '0) |->
      (push.res0.kind == K_INT || push.res0.kind == K_REAL))
    else $error("number value on a non-number token");

endmodule

>>> hdl/tlt_queue.sv
// Result queue that takes up to two words per cycle and delivers one per pop.
module tlt_queue import tlt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  push_t     push,
  output logic      space_ok,
  tlt_out_if.source out_ch
);

  res_t                entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic [QPTR_W-1:0]   wr_ptr_1;
  logic [1:0]          push_n;
  logic                pop;

  assign wr_ptr_1 = wr_ptr_r + QPTR_W'(1);
  assign push_n   = push_en ? push.count : 2'd0;
  assign pop      = out_ch.valid && out_ch.ready;

  // Room for a full pair keeps input acceptance independent of the output side.
  assign space_ok = (count_r <= (QPTR_W + 1)'(QUEUE_DEPTH - 2));

  // Head of the queue drives the output word.
  assign out_ch.valid        = (count_r != '0);
  assign out_ch.token_kind   = entry_r[rd_ptr_r].kind;
  assign out_ch.token_length = entry_r[rd_ptr_r].length;
  assign out_ch.number_value = entry_r[rd_ptr_r].value;
  assign out_ch.last_of_run  = entry_r[rd_ptr_r].last;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entry_r[wr_ptr_r] <= push.res0;
    if (push_n == 2'd2) entry_r[wr_ptr_1] <= push.res1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r  <= count_r + (QPTR_W + 1)'(push_n) - (QPTR_W + 1)'(pop);
    end
  end

  // The fill count never passes the depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A push only happens with room for a pair.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> space_ok)
    else $error("push without room");

  // A lone pop lowers the count by one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == 2'd0) |=> (count_r == $past(count_r) - (QPTR_W + 1)'(1)))
    else $error("fill count wrong after pop");

endmodule

>>> verif/tlt_token_checker.sv
// Checker that predicts the tokenizer's result words and compares them with the block's output.
`timescale 1ns / 100ps

module tlt_token_checker import tlt_pkg::*; #(
  parameter int LENGTH_BITS = LEN_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tlt_in_if    in_mon,
  tlt_out_if   out_mon,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   fail_count,
  output int   words_pending
);

  // Longest token length the block counts before it sticks.
  localparam longint unsigned RUN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

  // Mismatch reports stop here; counting goes on.
  localparam int REPORT_CAP = 100;

  // Scanner copy: current mode, bytes in the open token, integer part so far.
  logic [MODE_W-1:0]  scan_state;
  longint unsigned    run_len;
  logic [VALUE_W-1:0] int_part;
  logic               drop_ws;

  // Words caused by the byte being predicted, and all words still owed by the block.
  res_t               step_words [2];
  int                 step_count;
  res_t               token_queue [$];
  res_t               want;

  int                 mismatches = 0;
  int                 queued_words = 0;

  assign fail_count    = mismatches;
  assign words_pending = queued_words;

  function automatic bit blank_byte(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic bit name_stop(input logic [7:0] c);
    return blank_byte(c) || (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  // Queue one token word for this byte; dropped whitespace never appears.
  task automatic push_token(input logic [KIND_W-1:0] kind, input longint unsigned len,
                            input logic [VALUE_W-1:0] val);
    if (kind == K_SPACE && drop_ws) return;
    if (step_count >= 2) return;
    step_words[step_count] = '{kind: kind, length: len[LEN_W-1:0], value: val, last: 1'b0};
    step_count++;
  endtask

  task automatic extend_run();
    if (run_len < RUN_MAX) run_len++;
  endtask

  task automatic go_idle();
    scan_state = M_IDLE;
    run_len    = 0;
  endtask

  // Emit whatever token is open and return to idle.
  task automatic close_token();
    case (scan_state)
      M_WS:                        push_token(K_SPACE, run_len, '0);
      M_COMMENT:                   push_token(K_COMMENT, run_len, '0);
      M_AFTER_F, M_AFTER_LT, M_NAME: push_token(K_NAME, run_len, '0);
      M_AFTER_EQ:                  push_token(K_EQUALS, 1, '0);
      M_STRING:                    push_token(K_ERROR, run_len, '0);
      M_INT:                       push_token(K_INT, run_len, int_part);
      M_REAL:                      push_token(K_REAL, run_len, int_part);
      default: ;
    endcase
    go_idle();
    int_part = '0;
  endtask

  // Begin a token from an idle scanner; one-byte tokens come out at once.
  task automatic open_token(input logic [7:0] c);
    scan_state = M_IDLE;
    run_len    = 1;
    int_part   = '0;
    if (blank_byte(c)) scan_state = M_WS;
    else if (c == CH_LPAREN) push_token(K_LPAREN, 1, '0);
    else if (c == CH_RPAREN) push_token(K_RPAREN, 1, '0);
    else if (c == CH_LBRACE) push_token(K_LBRACE, 1, '0);
    else if (c == CH_RBRACE) push_token(K_RBRACE, 1, '0);
    else if (c == CH_SEMI) push_token(K_SEMI, 1, '0);
    else if (c == CH_HASH) scan_state = M_COMMENT;
    else if (c == CH_F) scan_state = M_AFTER_F;
    else if (c == CH_EQ) scan_state = M_AFTER_EQ;
    else if (c == CH_LT) scan_state = M_AFTER_LT;
    else if (c == CH_QUOTE) scan_state = M_STRING;
    else if (digit_byte(c)) begin
      scan_state = M_INT;
      int_part   = VALUE_W'(c - CH_DIG0);
    end else if (c >= NAME_LO && c <= NAME_HI) scan_state = M_NAME;
    else push_token(K_ERROR, 1, '0);
    if (scan_state == M_IDLE) run_len = 0;
  endtask

  // Advance the scanner by one source byte.
  task automatic scan_byte(input logic [7:0] c);
    longint unsigned grown;
    case (scan_state)
      M_WS: begin
        if (blank_byte(c)) begin
          extend_run();
          return;
        end
      end
      M_COMMENT: begin
        if (c != CH_NL) begin
          extend_run();
          return;
        end
      end
      M_AFTER_F, M_AFTER_LT: begin
        if ((scan_state == M_AFTER_F && c == CH_N) ||
            (scan_state == M_AFTER_LT && c == CH_DASH)) begin
          push_token((scan_state == M_AFTER_F) ? K_FN : K_LARROW, 2, '0);
          go_idle();
          return;
        end
        scan_state = M_NAME;
        if (!name_stop(c)) begin
          extend_run();
          return;
        end
      end
      M_AFTER_EQ: begin
        if (c == CH_GT) begin
          push_token(K_RARROW, 2, '0);
          go_idle();
          return;
        end
      end
      M_STRING: begin
        extend_run();
        if (c == CH_QUOTE) begin
          push_token(K_STR, run_len, '0);
          go_idle();
        end
        return;
      end
      M_INT: begin
        if (digit_byte(c)) begin
          grown    = 64'(int_part) * 64'd10 + 64'(c - CH_DIG0);
          int_part = (grown > 64'(VALUE_MAX)) ? VALUE_MAX : grown[VALUE_W-1:0];
          extend_run();
          return;
        end
        if (c == CH_DOT) begin
          extend_run();
          scan_state = M_REAL;
          return;
        end
      end
      M_REAL: begin
        if (digit_byte(c)) begin
          extend_run();
          return;
        end
      end
      M_NAME: begin
        if (!name_stop(c)) begin
          extend_run();
          return;
        end
      end
      default: ;
    endcase
    close_token();
    open_token(c);
  endtask

  // Work out the words one accepted input word causes and queue them.
  task automatic predict_word(input logic [7:0] c, input logic eoi);
    step_count = 0;
    if (eoi || c == CH_NUL) begin
      close_token();
      push_token(K_EOF, 0, '0);
    end else begin
      scan_byte(c);
    end
    if (step_count > 0) step_words[step_count-1].last = 1'b1;
    for (int i = 0; i < step_count; i++) token_queue.push_back(step_words[i]);
  endtask

  task automatic report_mismatch(input string field, input longint unsigned exp_val,
                                 input longint unsigned act_val);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
    end
  endtask

  // Outputs are checked before the new input is predicted: a byte taken at this edge
  // cannot have a word on the output yet.
  always @(posedge clk) begin
    if (!rst_n) begin
      scan_state = M_IDLE;
      run_len    = 0;
      int_part   = '0;
      drop_ws    = 1'b1;
      token_queue.delete();
    end else begin
      if (cfg_wr_en) drop_ws = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) begin
        if (token_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP) begin
            $error("token word with none expected: kind %0d length %0d value %0d",
                   out_mon.token_kind, out_mon.token_length, out_mon.number_value);
          end
        end else begin
          want = token_queue.pop_front();
          if (out_mon.token_kind !== want.kind)
            report_mismatch("token_kind", want.kind, out_mon.token_kind);
          if (out_mon.token_length !== want.length)
            report_mismatch("token_length", want.length, out_mon.token_length);
          if (out_mon.number_value !== want.value)
            report_mismatch("number_value", want.value, out_mon.number_value);
          if (out_mon.last_of_run !== want.last)
            report_mismatch("last_of_run", want.last, out_mon.last_of_run);
        end
      end
      if (in_mon.valid && in_mon.ready) predict_word(in_mon.char_code, in_mon.end_of_input);
    end
    queued_words = token_queue.size();
  end

endmodule

>>> verif/toy_language_tokenizer_test.sv
// Top of the tokenizer testbench: clock, reset, source stimulus, sink stalls and verdict.
`timescale 1ns / 100ps

module toy_language_tokenizer_test;
  import tlt_pkg::*;

  // Timeout, far above the slowest correct run.
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int LONG_RUN     = 200;
  localparam logic [7:0] CH_LOW_A = 8'd97;
  localparam logic [7:0] CH_LOW_Z = 8'd122;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  int   fail_count;
  int   words_pending;
  int   burst_left = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  bit   hold_off_go = 1'b0;

  tlt_in_if  in_ch ();
  tlt_out_if out_ch ();

  toy_language_tokenizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tlt_token_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #2 clk = ~clk;

  // Watchdog on the cycle count.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Sink side: segments of random stall density, and one long hold-off once random
  // traffic is running so the result queue fills and input ready drops.
  initial begin : receiver
    int seg_left;
    int ready_pct;
    bit long_done;
    seg_left  = 0;
    ready_pct = 100;
    long_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        if (hold_off_go && !long_done) begin
          long_done = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (400) @(negedge clk);
        end
        case ($urandom_range(0, 4))
          0, 1:    ready_pct = 100;
          2:       ready_pct = 80;
          3:       ready_pct = 50;
          default: ready_pct = 20;
        endcase
        seg_left = $urandom_range(20, 200);
      end
      out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      seg_left--;
    end
  end

  // Offer one word and hold it until it is taken; bursts with random gaps between them.
  // Called and left at a falling edge; valid stays high for the next word.
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_code    <= c;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Stop offering, let every owed word drain, then wait out the tail for bytes that
  // produce nothing.
  task automatic quiesce(input int tail);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_drop(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 5) == 5) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] punct_char();
    case ($urandom_range(0, 4))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_DIG0 + $urandom_range(0, 9));
  endfunction

  // A byte that keeps a name going.
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom_range(NAME_LO, NAME_HI));
    while (c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI);
    return c;
  endfunction

  // Any nonzero byte but the one that would close the token.
  function automatic logic [7:0] body_char(input logic [7:0] banned);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == banned);
    return c;
  endfunction

  // One well-formed token with random content, or now and then a stray byte.
  task automatic send_fragment();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        send_byte(8'($urandom_range(CH_LOW_A, CH_LOW_Z)), 1'b0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
        repeat (n) send_byte(name_char(), 1'b0);
      end
      3, 4: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (n) send_byte(digit_char(), 1'b0);
      end
      5: begin
        repeat ($urandom_range(1, 4)) send_byte(digit_char(), 1'b0);
        send_byte(CH_DOT, 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(digit_char(), 1'b0);
      end
      6, 7: begin
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 8)) send_byte(body_char(CH_QUOTE), 1'b0);
        send_byte(CH_QUOTE, 1'b0);
      end
      8, 9: repeat ($urandom_range(1, 4)) send_byte(blank_char(), 1'b0);
      10: begin
        send_byte(CH_HASH, 1'b0);
        repeat ($urandom_range(0, 10)) send_byte(body_char(CH_NL), 1'b0);
        send_byte(CH_NL, 1'b0);
      end
      11, 12: send_byte(punct_char(), 1'b0);
      13: send_text("fn");
      14: send_text("=>");
      15: send_text("<-");
      16: send_byte(CH_EQ, 1'b0);
      17: begin
        send_byte(($urandom_range(0, 1) == 1) ? CH_F : CH_LT, 1'b0);
        send_byte(name_char(), 1'b0);
      end
      18: send_byte(8'($urandom_range(0, 255)), 1'b0);
      default: send_byte(8'($urandom_range(NAME_HI + 1, 255)), 1'b0);
    endcase
  endtask

  // One source: tokens with random separators, closed by an end word, a zero byte,
  // or a string or comment left open.
  task automatic send_source();
    int sep;
    repeat ($urandom_range(1, 30)) begin
      send_fragment();
      sep = $urandom_range(0, 9);
      if (sep < 5) send_byte(blank_char(), 1'b0);
      else if (sep < 7) send_byte(punct_char(), 1'b0);
    end
    case ($urandom_range(0, 9))
      6, 7: send_byte(CH_NUL, 1'b0);
      8: begin
        send_byte(CH_QUOTE, 1'b0);
        send_byte(body_char(CH_QUOTE), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      9: begin
        send_byte(CH_HASH, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_byte(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  initial begin : stimulus
    int random_base;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.end_of_input = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: all kinds but integer and space, an equals closed by a paren (two words
    // from one byte), a bad byte, a real, a comment, then an end word that flushes a name.
    send_text("fn =><-=(){};");
    send_byte(8'hFF, 1'b0);
    send_text("\"a\"1.5#x\ng");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    // A string left open at a zero byte.
    send_text("\"b");
    send_byte(CH_NUL, 1'b0);
    // Whitespace kept.
    quiesce(4);
    write_drop(1'b0);
    send_text(" \t\n");
    send_byte(8'($urandom_range(0, 255)), 1'b1);

    // A long comment with arbitrary bytes, then scanning goes on.
    send_byte(CH_HASH, 1'b0);
    repeat (LONG_RUN) send_byte(body_char(CH_NL), 1'b0);
    send_text("\n12345678901;");
    send_byte(8'($urandom_range(0, 255)), 1'b1);

    // Random sources, with the whitespace setting changed between some of them.
    quiesce(4);
    write_drop(1'b1);
    hold_off_go = 1'b1;
    random_base = items_sent;
    while (items_sent < random_base + RANDOM_ITEMS) begin
      send_source();
      if ($urandom_range(0, 4) == 0) begin
        quiesce(4);
        write_drop(1'($urandom_range(0, 1)));
      end
    end

    quiesce(8);
    if (fail_count == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> toy_language_tokenizer.f
hdl/tlt_pkg.sv
hdl/tlt_in_if.sv
hdl/tlt_out_if.sv
hdl/tlt_scan.sv
hdl/tlt_queue.sv
hdl/toy_language_tokenizer.sv
verif/tlt_token_checker.sv
verif/toy_language_tokenizer_test.sv
